FILE: rtl/mcp_pkg.sv
// ----------------------------------------------------------------------
// mcp_pkg: shared types and constants of the min-cost path block
// Field widths, register indexes and saturation limits of the path sums.
// ----------------------------------------------------------------------
package mcp_pkg;

	localparam int CFG_W     = 7;   // widest configuration register
	localparam int CFG_IDX_W = 1;   // configuration register index
	localparam int IDX_W     = 7;   // row and column numbers on the output
	localparam int SUM_W     = 22;  // path sum as reported

	localparam int SUM_MAX = (2 ** (SUM_W - 1)) - 1;
	localparam int SUM_MIN = -(2 ** (SUM_W - 1));

	typedef logic [CFG_W-1:0]         cfg_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	localparam cfg_idx_t REG_ROW_COUNT    = 1'b0;
	localparam cfg_idx_t REG_COLUMN_COUNT = 1'b1;

	localparam cfg_t CFG_SIZE_RESET = 7'd64;

endpackage

FILE: rtl/mcp_ram.sv
// ----------------------------------------------------------------------
// mcp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------
module mcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/min_cost_path_west_to_east.sv
// ----------------------------------------------------------------------
// min_cost_path_west_to_east: cheapest west-to-east path through a grid
// Loads a grid of signed costs, runs the column DP in RAM, traces the
// path back and reports one request per column.
// ----------------------------------------------------------------------
// Usage
//   Config port: cfg_write_enable / cfg_index / cfg_data write row_count
//   or column_count (0 acts as 1, values above the maximum saturate).
//   A write while loading restarts the load. Write only while idle.
//   Input channel (in_valid / in_stall / cell_cost): one cost per request,
//   row-major, one per cycle while loading. in_stall is high from the
//   last cell of a grid until the last result is handed to the output
//   register.
//   Output channel (out_valid / out_stall / column_index, row_index,
//   total_cost, last_of_path): C requests in column order, last_of_path
//   set on the final column. out_stall just holds the output register;
//   loading of the next grid goes on while the last result waits.
//   Phases per grid (R rows, C columns): load, column DP (one cell per
//   cycle through the sum RAM read port, with the pipe drained after
//   each column), end-row scan, traceback (three neighbor reads per
//   column), then the results in column order.
//   Reset: registers back to 64 x 64, loading from the first cell.
//   Cost, sum and path RAMs need no clearing: every entry whose data is
//   used has been written for the current grid.
// ----------------------------------------------------------------------
module min_cost_path_west_to_east #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int COST_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_enable,
	input  mcp_pkg::cfg_idx_t            cfg_index,
	input  mcp_pkg::cfg_t                cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COST_WIDTH-1:0] cell_cost,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mcp_pkg::idx_t                column_index,
	output mcp_pkg::idx_t                row_index,
	output mcp_pkg::sum_t                total_cost,
	output logic                         last_of_path
);
	import mcp_pkg::*;

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RNW   = $clog2(MAX_ROWS + 1);
	localparam int CNW   = $clog2(MAX_COLS + 1);
	localparam int IW    = $clog2(MAX_ROWS + 3);
	localparam int SW    = (COST_WIDTH > SUM_W) ? COST_WIDTH : SUM_W;
	localparam int AW    = SW + 1;
	localparam int ADR_W = RW + CW;

	localparam logic signed [AW-1:0] SAT_HI = AW'(SUM_MAX);
	localparam logic signed [AW-1:0] SAT_LO = AW'(SUM_MIN);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DP,
		ST_SCAN,
		ST_TRACE,
		ST_EMIT
	} state_t;

	state_t state_q;

	cfg_t row_count_q, col_count_q;
	logic [RNW-1:0] rows_eff;
	logic [CNW-1:0] cols_eff;
	logic [RW-1:0]  rows_last;
	logic [CW-1:0]  cols_last;

	logic [RW-1:0] lr_q;     // load position
	logic [CW-1:0] lc_q;
	logic [CW-1:0] c_q;      // working column
	logic [IW-1:0] i_q;      // row step / sub-step
	logic [RW-1:0] u_q;      // path row
	logic signed [SW-1:0] best_q, a_q, b_q;

	logic out_valid_q, last_q;
	idx_t column_index_q, row_index_q;
	sum_t total_cost_q;

	// RAM ports
	logic                         cost_we;
	logic [ADR_W-1:0]             cost_waddr, cost_raddr;
	logic signed [COST_WIDTH-1:0] cost_rdata;
	logic                         sum_we;
	logic [ADR_W-1:0]             sum_waddr, sum_raddr;
	logic signed [SW-1:0]         sum_wdata, sum_rdata;
	logic                         path_we;
	logic [RW-1:0]                path_rdata;

	// DP pipeline
	logic                 dv_s1, top_ok_s1, bot_ok_s1;
	logic [RW-1:0]        drow_s1;
	logic [CW-1:0]        dcol_s1;
	logic                 dv_s2;
	logic [RW-1:0]        drow_s2;
	logic [CW-1:0]        dcol_s2;
	logic signed [SW-1:0] min_s2;
	logic signed [COST_WIDTH-1:0] cost_s2;
	logic signed [SW-1:0] win1_q, win2_q;   // previous-column sums r, r-1
	logic signed [SW-1:0] nb_min;
	logic signed [AW-1:0] sum_wide;
	logic signed [SW-1:0] sum_sat;

	// end-row scan pipeline
	logic          sv_s1, sfirst_s1;
	logic [RW-1:0] srow_s1;

	logic          in_take, load_last, dp_end, scan_end, emit_load;
	logic [CW-1:0] c_prev;
	logic [RW-1:0] row_above, row_below;
	logic          top_ok_tr, bot_ok_tr, go_up, go_dn;

	// ---------------- grid size ----------------
	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = RNW'(1);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rows_eff = RNW'(MAX_ROWS);
		end else begin
			rows_eff = RNW'(row_count_q);
		end
		if (col_count_q == '0) begin
			cols_eff = CNW'(1);
		end else if (int'(col_count_q) > MAX_COLS) begin
			cols_eff = CNW'(MAX_COLS);
		end else begin
			cols_eff = CNW'(col_count_q);
		end
	end

	assign rows_last = RW'(rows_eff - RNW'(1));
	assign cols_last = CW'(cols_eff - CNW'(1));

	// ---------------- control decodes ----------------
	assign in_stall  = (state_q != ST_LOAD);
	assign in_take   = in_valid && !in_stall;
	assign load_last = (lr_q == rows_last) && (lc_q == cols_last);
	// DP column: steps 0..R issue reads, the later steps up to R+2 drain the pipe
	assign dp_end    = (i_q == IW'(rows_eff) + IW'(2));
	assign scan_end  = (i_q == IW'(rows_eff));
	assign c_prev    = c_q - CW'(1);
	assign top_ok_tr = (u_q != '0);
	assign bot_ok_tr = (u_q != rows_last);
	assign row_above = top_ok_tr ? u_q - RW'(1) : u_q;
	assign row_below = bot_ok_tr ? u_q + RW'(1) : u_q;
	assign emit_load = (state_q == ST_EMIT) && (i_q != '0) && (!out_valid_q || !out_stall);

	// traceback choice: above wins ties, then below, else stay
	// a_q = sum above, b_q = same row, sum_rdata = below
	always_comb begin
		go_up = top_ok_tr && (a_q <= b_q) && (!bot_ok_tr || (a_q <= sum_rdata));
		go_dn = !go_up && bot_ok_tr && (sum_rdata <= b_q) &&
			(!top_ok_tr || (sum_rdata < a_q));
	end

	// ---------------- RAM addressing ----------------
	assign cost_we    = in_take;
	assign cost_waddr = {lr_q, lc_q};
	assign cost_raddr = {RW'(i_q - IW'(1)), c_q};

	always_comb begin
		if (state_q == ST_LOAD) begin
			// column 1 sums are the costs themselves
			sum_we    = in_take && (lc_q == '0);
			sum_waddr = {lr_q, lc_q};
			sum_wdata = SW'(cell_cost);
		end else begin
			sum_we    = dv_s2;
			sum_waddr = {drow_s2, dcol_s2};
			sum_wdata = sum_sat;
		end
	end

	always_comb begin
		case (state_q)
			ST_DP:   sum_raddr = {RW'(i_q), c_prev};
			ST_SCAN: sum_raddr = {RW'(i_q), cols_last};
			ST_TRACE: begin
				if (i_q == IW'(0)) begin
					sum_raddr = {row_above, c_prev};
				end else if (i_q == IW'(1)) begin
					sum_raddr = {u_q, c_prev};
				end else begin
					sum_raddr = {row_below, c_prev};
				end
			end
			default: sum_raddr = {RW'(i_q), c_q};
		endcase
	end

	assign path_we = (state_q == ST_TRACE) && (i_q == '0);

	mcp_ram #(.WIDTH(COST_WIDTH), .DEPTH(2 ** ADR_W)) u_cost_ram (
		.clk   (clk),
		.we    (cost_we),
		.waddr (cost_waddr),
		.wdata (cell_cost),
		.raddr (cost_raddr),
		.rdata (cost_rdata)
	);

	mcp_ram #(.WIDTH(SW), .DEPTH(2 ** ADR_W)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	mcp_ram #(.WIDTH(RW), .DEPTH(2 ** CW)) u_path_ram (
		.clk   (clk),
		.we    (path_we),
		.waddr (c_q),
		.wdata (u_q),
		.raddr (c_q),
		.rdata (path_rdata)
	);

	// ---------------- DP datapath ----------------
	// s1: sum_rdata = row r+1 of the previous column, window holds r, r-1
	always_comb begin
		nb_min = win1_q;
		if (top_ok_s1 && (win2_q < nb_min)) begin
			nb_min = win2_q;
		end
		if (bot_ok_s1 && (sum_rdata < nb_min)) begin
			nb_min = sum_rdata;
		end
	end

	// s2: add cost, saturate to the reported sum range
	always_comb begin
		sum_wide = AW'(min_s2) + AW'(cost_s2);
		if (sum_wide > SAT_HI) begin
			sum_sat = SW'(SAT_HI);
		end else if (sum_wide < SAT_LO) begin
			sum_sat = SW'(SAT_LO);
		end else begin
			sum_sat = SW'(sum_wide);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s1 <= 1'b0;
			dv_s2 <= 1'b0;
			sv_s1 <= 1'b0;
		end else begin
			dv_s1 <= (state_q == ST_DP) && (i_q != '0) && (i_q <= IW'(rows_eff));
			dv_s2 <= dv_s1;
			sv_s1 <= (state_q == ST_SCAN) && (i_q < IW'(rows_eff));
		end
	end

	always_ff @(posedge clk) begin
		drow_s1   <= RW'(i_q - IW'(1));
		dcol_s1   <= c_q;
		top_ok_s1 <= (i_q >= IW'(2));
		bot_ok_s1 <= (i_q < IW'(rows_eff));
		win1_q    <= sum_rdata;
		win2_q    <= win1_q;
		drow_s2   <= drow_s1;
		dcol_s2   <= dcol_s1;
		min_s2    <= nb_min;
		cost_s2   <= cost_rdata;
		srow_s1   <= RW'(i_q);
		sfirst_s1 <= (i_q == '0);
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			row_count_q    <= CFG_SIZE_RESET;
			col_count_q    <= CFG_SIZE_RESET;
			lr_q           <= '0;
			lc_q           <= '0;
			c_q            <= '0;
			i_q            <= '0;
			u_q            <= '0;
			best_q         <= '0;
			a_q            <= '0;
			b_q            <= '0;
			out_valid_q    <= 1'b0;
			column_index_q <= '0;
			row_index_q    <= '0;
			total_cost_q   <= '0;
			last_q         <= 1'b0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_LOAD: begin
					if (cfg_write_enable) begin
						// register write restarts the grid load
						lr_q <= '0;
						lc_q <= '0;
					end else if (in_take) begin
						if (load_last) begin
							lr_q <= '0;
							lc_q <= '0;
							i_q  <= '0;
							if (cols_last == '0) begin
								state_q <= ST_SCAN;
							end else begin
								c_q     <= CW'(1);
								state_q <= ST_DP;
							end
						end else if (lc_q == cols_last) begin
							lc_q <= '0;
							lr_q <= lr_q + RW'(1);
						end else begin
							lc_q <= lc_q + CW'(1);
						end
					end
				end

				ST_DP: begin
					if (dp_end) begin
						i_q <= '0;
						if (c_q == cols_last) begin
							state_q <= ST_SCAN;
						end else begin
							c_q <= c_q + CW'(1);
						end
					end else begin
						i_q <= i_q + IW'(1);
					end
				end

				ST_SCAN: begin
					// first strictly smaller sum keeps the lowest row
					if (sv_s1 && (sfirst_s1 || (sum_rdata < best_q))) begin
						best_q <= sum_rdata;
						u_q    <= srow_s1;
					end
					if (scan_end) begin
						i_q     <= '0;
						c_q     <= cols_last;
						state_q <= ST_TRACE;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end

				ST_TRACE: begin
					// step 0 records the row, steps 1..3 collect neighbors
					if (i_q == IW'(0)) begin
						if (c_q == '0) begin
							state_q <= ST_EMIT;
						end else begin
							i_q <= IW'(1);
						end
					end else if (i_q == IW'(1)) begin
						a_q <= sum_rdata;
						i_q <= IW'(2);
					end else if (i_q == IW'(2)) begin
						b_q <= sum_rdata;
						i_q <= IW'(3);
					end else begin
						if (go_up) begin
							u_q <= u_q - RW'(1);
						end else if (go_dn) begin
							u_q <= u_q + RW'(1);
						end
						c_q <= c_prev;
						i_q <= '0;
					end
				end

				ST_EMIT: begin
					if (i_q == '0) begin
						i_q <= IW'(1);
					end else if (emit_load) begin
						column_index_q <= IDX_W'(c_q) + IDX_W'(1);
						row_index_q    <= IDX_W'(path_rdata) + IDX_W'(1);
						total_cost_q   <= best_q[SUM_W-1:0];
						last_q         <= (c_q == cols_last);
						i_q            <= '0;
						if (c_q == cols_last) begin
							c_q     <= '0;
							state_q <= ST_LOAD;
						end else begin
							c_q <= c_q + CW'(1);
						end
					end
				end

				default: state_q <= ST_LOAD;
			endcase

			if (cfg_write_enable) begin
				case (cfg_index)
					REG_ROW_COUNT:    row_count_q <= cfg_data;
					REG_COLUMN_COUNT: col_count_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign column_index = column_index_q;
	assign row_index    = row_index_q;
	assign total_cost   = total_cost_q;
	assign last_of_path = last_q;

endmodule

FILE: rtl/mcp_checker.sv
// ----------------------------------------------------------------------
// mcp_checker: port-level checks of the min-cost path block
// Held stalled requests, column order, constant total and unit row steps along one path.
// ----------------------------------------------------------------------
module mcp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_stall,
	input mcp_pkg::idx_t column_index,
	input mcp_pkg::idx_t row_index,
	input mcp_pkg::sum_t total_cost,
	input logic          last_of_path
);
	import mcp_pkg::*;

	idx_t exp_col_q;
	idx_t prev_row_q;
	sum_t prev_cost_q;
	logic out_take;

	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_col_q   <= IDX_W'(1);
			prev_row_q  <= '0;
			prev_cost_q <= '0;
		end else if (out_take) begin
			exp_col_q   <= last_of_path ? IDX_W'(1) : column_index + IDX_W'(1);
			prev_row_q  <= row_index;
			prev_cost_q <= total_cost;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(column_index) &&
			$stable(row_index) && $stable(total_cost) && $stable(last_of_path))
		else $error("stalled request changed");

	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> column_index == exp_col_q)
		else $error("column out of order");

	a_cost_const: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (exp_col_q != IDX_W'(1)) |-> total_cost == prev_cost_q)
		else $error("total cost changed along path");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (exp_col_q != IDX_W'(1)) |->
			(row_index == prev_row_q) || (row_index == prev_row_q + IDX_W'(1)) ||
			(row_index + IDX_W'(1) == prev_row_q))
		else $error("path jumps more than one row");

endmodule

bind min_cost_path_west_to_east mcp_checker u_mcp_checker (.*);
